// ----- src/lcrc_pkg.sv -----
// Package: shared types, constants and command/status structs of the line clipper.
`timescale 1ns / 1ps
package lcrc_pkg;
   localparam int COORD_BITS = 16;
   // internal width holds any input coordinate and any window edge
   localparam int INT_BITS = (COORD_BITS > 16) ? COORD_BITS : 16;
   localparam int CNT_BITS = $clog2(INT_BITS + 1);
   localparam int CSR_BITS = 15;
   localparam int CSR_IDX_BITS = 2;
   localparam int MOVE_BITS = 3;
   localparam logic [MOVE_BITS-1:0] MAX_MOVES = 3'd4;

   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_HEIGHT = 2'd1;
   localparam logic [CSR_BITS-1:0] WINDOW_WIDTH_RESET  = 15'd200;
   localparam logic [CSR_BITS-1:0] WINDOW_HEIGHT_RESET = 15'd200;

   // region code bits
   localparam int CODE_TOP    = 3;
   localparam int CODE_BOTTOM = 2;
   localparam int CODE_RIGHT  = 1;
   localparam int CODE_LEFT   = 0;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [INT_BITS-1:0]   icoord_type;
   typedef logic signed [INT_BITS:0]     diff_type;
   typedef logic [INT_BITS-1:0]          mag_type;
   typedef logic [2*INT_BITS-1:0]        prod_type;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
   } req_type;

   typedef struct packed {
      logic      accepted;
      coord_type clip_start_x;
      coord_type clip_start_y;
      coord_type clip_end_x;
      coord_type clip_end_y;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic setup;
      logic mul;
      logic div_start;
      logic apply;
      logic finish;
      logic accept;
   } cmd_type;

   typedef struct packed {
      logic accept_now;
      logic reject_now;
      logic den_zero;
      logic div_done;
   } status_type;
endpackage

// ----- src/lcrc_divider.sv -----
// Restoring divider, one quotient bit per cycle, for the clip interpolation.
`timescale 1ns / 1ps
module lcrc_divider (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  lcrc_pkg::prod_type       dividend,
   input  lcrc_pkg::mag_type        divisor,
   output lcrc_pkg::mag_type        quotient,
   output logic                     done
);
   import lcrc_pkg::*;

   mag_type rem_ff, rem_in;
   mag_type low_ff, low_in;
   mag_type div_ff, div_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic run_ff, run_in;
   logic done_ff, done_in;
   logic [INT_BITS:0] rem_sh;
   logic [INT_BITS:0] rem_sub;
   logic take;

   always_comb begin
      rem_sh  = {rem_ff, low_ff[INT_BITS-1]};
      rem_sub = rem_sh - {1'b0, div_ff};
      take    = !rem_sub[INT_BITS];
      rem_in  = rem_ff;
      low_in  = low_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         // high half is already below the divisor since |b| <= |c|
         rem_in = dividend[2*INT_BITS-1:INT_BITS];
         low_in = dividend[INT_BITS-1:0];
         div_in = divisor;
         cnt_in = CNT_BITS'(INT_BITS);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = take ? rem_sub[INT_BITS-1:0] : rem_sh[INT_BITS-1:0];
         low_in = {low_ff[INT_BITS-2:0], take};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      div_ff <= div_in;
   end

   assign quotient = low_ff;
   assign done     = done_ff;
endmodule

// ----- src/lcrc_datapath.sv -----
// Datapath: endpoint registers, region codes, operand setup, multiplier and divider.
`timescale 1ns / 1ps
module lcrc_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  lcrc_pkg::cmd_type                 cmd,
   output lcrc_pkg::status_type              status,
   input  lcrc_pkg::req_type                 req_item,
   output lcrc_pkg::rsp_type                 rsp_item,
   input  logic                              csr_we,
   input  logic [lcrc_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [lcrc_pkg::CSR_BITS-1:0]     csr_wdata
);
   import lcrc_pkg::*;

   logic [CSR_BITS-1:0] width_ff, height_ff;
   icoord_type sx_ff, sy_ff, ex_ff, ey_ff;
   icoord_type sx_in, sy_in, ex_in, ey_in;
   mag_type mag_a_ff, mag_b_ff, mag_c_ff;
   logic neg_ff, axis_x_ff, move_start_ff;
   icoord_type p_ff, edge_ff;
   prod_type prod_ff;
   rsp_type rsp_ff;

   logic [3:0] cs, ce, code;
   icoord_type w_ext, h_ext, edge_sel;
   logic axis_x;
   diff_type da, db, dc;
   mag_type quotient;
   logic div_done;
   diff_type q_signed, new_sum;
   icoord_type new_val;

   function automatic logic [3:0] region(icoord_type x, icoord_type y,
                                         icoord_type w, icoord_type h);
      logic [3:0] c;
      c = '0;
      c[CODE_TOP]    = y > h;
      c[CODE_BOTTOM] = y < 0;
      c[CODE_RIGHT]  = x > w;
      c[CODE_LEFT]   = x < 0;
      return c;
   endfunction

   function automatic mag_type magnitude(diff_type d);
      diff_type n;
      n = -d;
      return d[INT_BITS] ? n[INT_BITS-1:0] : d[INT_BITS-1:0];
   endfunction

   always_comb begin
      w_ext  = icoord_type'({1'b0, width_ff});
      h_ext  = icoord_type'({1'b0, height_ff});
      cs     = region(sx_ff, sy_ff, w_ext, h_ext);
      ce     = region(ex_ff, ey_ff, w_ext, h_ext);
      code   = (cs != 4'd0) ? cs : ce;
      axis_x = code[CODE_LEFT] | code[CODE_RIGHT];
      if (axis_x) begin
         edge_sel = code[CODE_LEFT] ? icoord_type'(0) : w_ext;
         da = diff_type'(ey_ff) - diff_type'(sy_ff);
         db = diff_type'(edge_sel) - diff_type'(sx_ff);
         dc = diff_type'(ex_ff) - diff_type'(sx_ff);
      end else begin
         edge_sel = code[CODE_BOTTOM] ? icoord_type'(0) : h_ext;
         da = diff_type'(ex_ff) - diff_type'(sx_ff);
         db = diff_type'(edge_sel) - diff_type'(sy_ff);
         dc = diff_type'(ey_ff) - diff_type'(sy_ff);
      end
      status.accept_now = (cs | ce) == 4'd0;
      status.reject_now = (cs & ce) != 4'd0;
      status.den_zero   = dc == '0;
      status.div_done   = div_done;

      q_signed = neg_ff ? -diff_type'({1'b0, quotient}) : diff_type'({1'b0, quotient});
      new_sum  = diff_type'(p_ff) + q_signed;
      new_val  = new_sum[INT_BITS-1:0];

      sx_in = sx_ff;
      sy_in = sy_ff;
      ex_in = ex_ff;
      ey_in = ey_ff;
      if (cmd.load) begin
         sx_in = icoord_type'(req_item.start_x);
         sy_in = icoord_type'(req_item.start_y);
         ex_in = icoord_type'(req_item.end_x);
         ey_in = icoord_type'(req_item.end_y);
      end else if (cmd.apply) begin
         if (move_start_ff) begin
            sx_in = axis_x_ff ? edge_ff : new_val;
            sy_in = axis_x_ff ? new_val : edge_ff;
         end else begin
            ex_in = axis_x_ff ? edge_ff : new_val;
            ey_in = axis_x_ff ? new_val : edge_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WINDOW_WIDTH_RESET;
         height_ff <= WINDOW_HEIGHT_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_WINDOW_WIDTH) width_ff <= csr_wdata;
         if (csr_index == CSR_WINDOW_HEIGHT) height_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      sx_ff <= sx_in;
      sy_ff <= sy_in;
      ex_ff <= ex_in;
      ey_ff <= ey_in;
      if (cmd.setup) begin
         mag_a_ff      <= magnitude(da);
         mag_b_ff      <= magnitude(db);
         mag_c_ff      <= magnitude(dc);
         neg_ff        <= da[INT_BITS] ^ db[INT_BITS] ^ dc[INT_BITS];
         axis_x_ff     <= axis_x;
         move_start_ff <= cs != 4'd0;
         p_ff          <= axis_x ? sy_ff : sx_ff;
         edge_ff       <= edge_sel;
      end
      if (cmd.mul) prod_ff <= prod_type'(mag_a_ff) * prod_type'(mag_b_ff);
      if (cmd.finish) begin
         rsp_ff.accepted     <= cmd.accept;
         rsp_ff.clip_start_x <= sx_ff[COORD_BITS-1:0];
         rsp_ff.clip_start_y <= sy_ff[COORD_BITS-1:0];
         rsp_ff.clip_end_x   <= ex_ff[COORD_BITS-1:0];
         rsp_ff.clip_end_y   <= ey_ff[COORD_BITS-1:0];
      end
   end

   lcrc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff),
      .divisor  (mag_c_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   assign rsp_item = rsp_ff;
endmodule

// ----- src/lcrc_ctrl.sv -----
// Controller: sequences region checks and up to four clip moves per item.
`timescale 1ns / 1ps
module lcrc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   output lcrc_pkg::cmd_type    cmd,
   input  lcrc_pkg::status_type status
);
   import lcrc_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_DSTRT = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [MOVE_BITS-1:0] moves_ff, moves_in;
   logic valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      moves_in = moves_ff;
      valid_in = 1'b0;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               moves_in = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            priority if (status.accept_now) begin
               cmd.finish = 1'b1;
               cmd.accept = 1'b1;
               valid_in   = 1'b1;
               state_in   = ST_IDLE;
            end else if (status.reject_now || moves_ff == MAX_MOVES || status.den_zero) begin
               cmd.finish = 1'b1;
               valid_in   = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.setup = 1'b1;
               moves_in  = moves_ff + 1'b1;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DSTRT;
         end
         ST_DSTRT: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) begin
               cmd.apply = 1'b1;
               state_in  = ST_CHECK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         moves_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         moves_ff <= moves_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = valid_ff;
endmodule

// ----- src/line_clipper_region_codes.sv -----
// Top level of the region-code line clipper.
//
//   channel  ports                          handshake
//   request  start, busy, req_item          accepted when start && !busy
//   result   rsp_valid, rsp_item            one-cycle strobe, no backpressure
//   config   csr_we, csr_index, csr_wdata   written when csr_we
//
// An item is checked, then takes up to four endpoint moves, each of setup,
// multiply, divider start and divide. The shared one-bit-a-cycle divider
// sets the cost of each move. Busy is high from acceptance to the result
// strobe; busy falls in the cycle the strobe shows. Synchronous reset sets
// the window to 200 x 200 and idles the controller. The receiver cannot stall.
`timescale 1ns / 1ps
module line_clipper_region_codes (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  lcrc_pkg::req_type                 req_item,
   output logic                              rsp_valid,
   output lcrc_pkg::rsp_type                 rsp_item,
   input  logic                              csr_we,
   input  logic [lcrc_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [lcrc_pkg::CSR_BITS-1:0]     csr_wdata
);
   import lcrc_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       accept_item;

   // a start while busy is ignored
   assign accept_item = start & !busy;

   lcrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (accept_item),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   lcrc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_item  (req_item),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );
endmodule

// ----- src/lcrc_checker.sv -----
// Port-level checker for the line clipper, bound to the top level.
`timescale 1ns / 1ps
module lcrc_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted item did not raise busy");
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without an item in work");
   a_busy_ends_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid) else $error("item finished without result");
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than a cycle");
endmodule

bind line_clipper_region_codes lcrc_checker u_lcrc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);
